/* rtl/core/cpgg_pkg.sv */
// Shared types, constants and microcode program of the cubic planar graph grower.
// Used by the channel interfaces, the sequencer, the datapath and the top level.
package cpgg_pkg;

  localparam int unsigned MaxNodes    = 512;
  localparam int unsigned NodeFieldW  = 9;
  localparam int unsigned CountFieldW = 10;
  localparam int unsigned StepW       = 5;

  typedef logic [1:0]             op_t;
  typedef logic [1:0]             slot_t;
  typedef logic [1:0]             status_t;
  typedef logic [NodeFieldW-1:0]  node_field_t;
  typedef logic [CountFieldW-1:0] count_field_t;
  typedef logic [StepW-1:0]       step_t;

  localparam op_t OP_GROW    = 2'd0;
  localparam op_t OP_READ    = 2'd1;
  localparam op_t OP_RESTART = 2'd2;

  localparam slot_t SLOT_NONE = 2'd3;

  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_RANGE = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

  // Program addresses
  localparam step_t STEP_IDLE   = 5'd0;
  localparam step_t STEP_G0     = 5'd1;
  localparam step_t STEP_G1     = 5'd2;
  localparam step_t STEP_G2     = 5'd3;
  localparam step_t STEP_G3     = 5'd4;
  localparam step_t STEP_G4     = 5'd5;
  localparam step_t STEP_G5     = 5'd6;
  localparam step_t STEP_G6     = 5'd7;
  localparam step_t STEP_G7     = 5'd8;
  localparam step_t STEP_G8     = 5'd9;
  localparam step_t STEP_G9     = 5'd10;
  localparam step_t STEP_G10    = 5'd11;
  localparam step_t STEP_R0     = 5'd12;
  localparam step_t STEP_R1     = 5'd13;
  localparam step_t STEP_ERANGE = 5'd14;
  localparam step_t STEP_EFULL  = 5'd15;
  localparam step_t STEP_K0     = 5'd16;
  localparam step_t STEP_K1     = 5'd17;
  localparam step_t STEP_K2     = 5'd18;
  localparam step_t STEP_K3     = 5'd19;
  localparam step_t STEP_KEND   = 5'd20;
  localparam step_t STEP_KEMIT  = 5'd21;
  localparam step_t STEP_LAST   = STEP_KEMIT;

  typedef enum logic [4:0] {
    A_NOP,
    A_LATCH,
    A_RD_U,
    A_GET_V,
    A_RD_V,
    A_GET_W,
    A_RD_W,
    A_WR_U,
    A_WR_W,
    A_WR_V,
    A_WR_A,
    A_WR_B,
    A_RD_R,
    A_K4,
    A_INIT_DONE,
    A_EMIT_GROW,
    A_EMIT_READ,
    A_EMIT_RANGE,
    A_EMIT_FULL,
    A_EMIT_OK
  } act_e;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_DISPATCH,
    C_RANGE,
    C_FULL,
    C_V_BAD,
    C_W_BAD,
    C_R_BAD,
    C_INIT
  } cond_e;

  typedef struct packed {
    act_e       act;
    cond_e      cond;
    step_t      target;
    logic [1:0] k_row;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    op_t  op;
    logic range_bad;
    logic full;
    logic v_bad;
    logic w_bad;
    logic r_bad;
    logic out_busy;
  } flags_t;

  function automatic uword_t ucode(step_t s);
    uword_t uw;
    uw = '{act: A_NOP, cond: C_ALWAYS, target: STEP_IDLE, k_row: 2'd0};
    unique case (s)
      STEP_IDLE:   uw = '{A_LATCH,      C_DISPATCH, STEP_IDLE,   2'd0};
      STEP_G0:     uw = '{A_RD_U,       C_RANGE,    STEP_ERANGE, 2'd0};
      STEP_G1:     uw = '{A_GET_V,      C_FULL,     STEP_EFULL,  2'd0};
      STEP_G2:     uw = '{A_RD_V,       C_V_BAD,    STEP_ERANGE, 2'd0};
      STEP_G3:     uw = '{A_GET_W,      C_NEXT,     STEP_IDLE,   2'd0};
      STEP_G4:     uw = '{A_RD_W,       C_W_BAD,    STEP_ERANGE, 2'd0};
      STEP_G5:     uw = '{A_WR_U,       C_NEXT,     STEP_IDLE,   2'd0};
      STEP_G6:     uw = '{A_WR_W,       C_NEXT,     STEP_IDLE,   2'd0};
      STEP_G7:     uw = '{A_WR_V,       C_NEXT,     STEP_IDLE,   2'd0};
      STEP_G8:     uw = '{A_WR_A,       C_NEXT,     STEP_IDLE,   2'd0};
      STEP_G9:     uw = '{A_WR_B,       C_NEXT,     STEP_IDLE,   2'd0};
      STEP_G10:    uw = '{A_EMIT_GROW,  C_ALWAYS,   STEP_IDLE,   2'd0};
      STEP_R0:     uw = '{A_RD_R,       C_R_BAD,    STEP_ERANGE, 2'd0};
      STEP_R1:     uw = '{A_EMIT_READ,  C_ALWAYS,   STEP_IDLE,   2'd0};
      STEP_ERANGE: uw = '{A_EMIT_RANGE, C_ALWAYS,   STEP_IDLE,   2'd0};
      STEP_EFULL:  uw = '{A_EMIT_FULL,  C_ALWAYS,   STEP_IDLE,   2'd0};
      STEP_K0:     uw = '{A_K4,         C_NEXT,     STEP_IDLE,   2'd0};
      STEP_K1:     uw = '{A_K4,         C_NEXT,     STEP_IDLE,   2'd1};
      STEP_K2:     uw = '{A_K4,         C_NEXT,     STEP_IDLE,   2'd2};
      STEP_K3:     uw = '{A_K4,         C_NEXT,     STEP_IDLE,   2'd3};
      STEP_KEND:   uw = '{A_INIT_DONE,  C_INIT,     STEP_IDLE,   2'd0};
      STEP_KEMIT:  uw = '{A_EMIT_OK,    C_ALWAYS,   STEP_IDLE,   2'd0};
      default:     uw = '{A_NOP,        C_ALWAYS,   STEP_IDLE,   2'd0};
    endcase
    return uw;
  endfunction

  function automatic step_t dispatch(op_t op);
    step_t s;
    unique case (op)
      OP_GROW:    s = STEP_G0;
      OP_READ:    s = STEP_R0;
      OP_RESTART: s = STEP_K0;
      default:    s = STEP_ERANGE;
    endcase
    return s;
  endfunction

  function automatic logic is_emit(act_e a);
    logic e;
    case (a) inside
      A_EMIT_GROW, A_EMIT_READ, A_EMIT_RANGE, A_EMIT_FULL, A_EMIT_OK: e = 1'b1;
      default: e = 1'b0;
    endcase
    return e;
  endfunction

  // K4 rotation: 0:{2,1,3} 1:{0,2,3} 2:{3,1,0} 3:{0,1,2}
  function automatic logic [1:0] k4_node(logic [1:0] row, logic [1:0] slot);
    logic [5:0] r;
    unique case (row)
      2'd0:    r = {2'd3, 2'd1, 2'd2};
      2'd1:    r = {2'd3, 2'd2, 2'd0};
      2'd2:    r = {2'd0, 2'd1, 2'd3};
      default: r = {2'd2, 2'd1, 2'd0};
    endcase
    return r[slot*2 +: 2];
  endfunction

endpackage

/* rtl/core/cpgg_if.sv */
// Request and response channel interfaces of the cubic planar graph grower.
// Depends on cpgg_pkg for the field types.
interface cpgg_req_if;
  import cpgg_pkg::*;
  logic        valid;
  logic        ready;
  op_t         operation;
  node_field_t edge_node;
  slot_t       edge_slot;
  node_field_t read_node;

  modport source (output valid, operation, edge_node, edge_slot, read_node, input ready);
  modport sink   (input valid, operation, edge_node, edge_slot, read_node, output ready);
endinterface

interface cpgg_rsp_if;
  import cpgg_pkg::*;
  logic         valid;
  logic         ready;
  status_t      status;
  count_field_t node_count;
  node_field_t  first_new_node;
  node_field_t  neighbour_first;
  node_field_t  neighbour_second;
  node_field_t  neighbour_third;

  modport source (output valid, status, node_count, first_new_node, neighbour_first,
                  neighbour_second, neighbour_third, input ready);
  modport sink   (input valid, status, node_count, first_new_node, neighbour_first,
                  neighbour_second, neighbour_third, output ready);
endinterface

/* rtl/core/cpgg_sequencer.sv */
// Microcode sequencer: step counter, program ROM, branch and dispatch logic.
// Depends on cpgg_pkg for the control word, flag struct and program.
module cpgg_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cpgg_pkg::flags_t flags_i,
  output cpgg_pkg::uword_t ctl_o
);
  import cpgg_pkg::*;

  step_t  step_q, step_d;
  logic   init_q, init_d;
  uword_t uw;
  logic   cond_hit;

  assign uw    = ucode(step_q);
  assign ctl_o = uw;

  always_comb begin
    unique case (uw.cond)
      C_RANGE: cond_hit = flags_i.range_bad;
      C_FULL:  cond_hit = flags_i.full;
      C_V_BAD: cond_hit = flags_i.v_bad;
      C_W_BAD: cond_hit = flags_i.w_bad;
      C_R_BAD: cond_hit = flags_i.r_bad;
      C_INIT:  cond_hit = init_q;
      default: cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    step_d = step_q;
    init_d = init_q;
    if (uw.act == A_INIT_DONE) begin
      init_d = 1'b0;
    end
    if (is_emit(uw.act) && flags_i.out_busy) begin
      step_d = step_q;  // hold until the result register frees up
    end else begin
      unique case (uw.cond)
        C_NEXT:     step_d = step_q + step_t'(1);
        C_ALWAYS:   step_d = uw.target;
        C_DISPATCH: step_d = flags_i.in_valid ? dispatch(flags_i.op) : step_q;
        default:    step_d = cond_hit ? uw.target : step_q + step_t'(1);
      endcase
    end
  end

  // After reset, run the K4 load program before accepting requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_K0;
      init_q <= 1'b1;
    end else begin
      step_q <= step_d;
      init_q <= init_d;
    end
  end

`ifndef ASSERT_OFF
  a_step_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_LAST) else $error("step counter left the program");
  a_init_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> (step_q >= STEP_K0 && step_q <= STEP_KEND))
    else $error("initial load left the K4 program");
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_emit(uw.act) && flags_i.out_busy) |=> $stable(step_q))
    else $error("step advanced while result register was busy");
`endif

endmodule

/* rtl/core/cpgg_datapath.sv */
// Datapath: rotation table memory, working registers, node counter, result register.
// Driven by control words from cpgg_sequencer; depends on cpgg_pkg and cpgg_if.
module cpgg_datapath #(
  parameter int unsigned TABLE_DEPTH = cpgg_pkg::MaxNodes
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cpgg_pkg::uword_t ctl_i,
  output cpgg_pkg::flags_t flags_o,
  cpgg_req_if.sink         req_i,
  cpgg_rsp_if.source       rsp_o
);
  import cpgg_pkg::*;

  localparam int unsigned NW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RowW = 3 * NW;
  localparam int unsigned CmpW = (CW > NodeFieldW) ? CW : NodeFieldW;

  typedef logic [NW-1:0]   node_t;
  typedef logic [CW-1:0]   cnt_t;
  typedef logic [RowW-1:0] row_t;

  row_t mem_q [TABLE_DEPTH];
  row_t rdata_q;

  node_field_t u_q, rnode_q;
  slot_t       slot_q;
  node_t       v_q, w_q, a_q, b;
  row_t        row_u_q, row_v_q, row_w_q;
  cnt_t        cnt_q;

  logic  rd_en, wr_en;
  node_t rd_addr, wr_addr;
  row_t  wr_data;
  node_t u_n;
  logic  out_busy, emit_fire;

  logic         out_valid_q;
  status_t      out_status_q;
  count_field_t out_count_q;
  node_field_t  out_first_q;
  node_field_t  out_nb0_q, out_nb1_q, out_nb2_q;

  assign u_n = NW'(u_q);
  assign b   = a_q + node_t'(1);

  assign req_i.ready = (ctl_i.act == A_LATCH);

  assign out_busy  = out_valid_q && !rsp_o.ready;
  assign emit_fire = is_emit(ctl_i.act) && !out_busy;

  assign flags_o.in_valid  = req_i.valid;
  assign flags_o.op        = req_i.operation;
  assign flags_o.range_bad = (CmpW'(u_q) >= CmpW'(cnt_q)) || (slot_q == SLOT_NONE);
  assign flags_o.full      = cnt_q > cnt_t'(TABLE_DEPTH - 2);
  assign flags_o.v_bad     = cnt_t'(v_q) >= cnt_q;
  assign flags_o.w_bad     = cnt_t'(w_q) >= cnt_q;
  assign flags_o.r_bad     = CmpW'(rnode_q) >= CmpW'(cnt_q);
  assign flags_o.out_busy  = out_busy;

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (ctl_i.act)
      A_RD_U:  begin rd_en = 1'b1; rd_addr = u_n; end
      A_RD_V:  begin rd_en = 1'b1; rd_addr = v_q; end
      A_RD_W:  begin rd_en = 1'b1; rd_addr = w_q; end
      A_RD_R:  begin rd_en = 1'b1; rd_addr = NW'(rnode_q); end
      default: begin rd_en = 1'b0; rd_addr = '0; end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (ctl_i.act)
      A_WR_U: begin
        wr_en   = 1'b1;
        wr_addr = u_n;
        for (int s = 0; s < 3; s++) begin
          wr_data[s*NW +: NW] = (row_u_q[s*NW +: NW] == v_q) ? a_q : row_u_q[s*NW +: NW];
        end
      end
      A_WR_W: begin
        wr_en   = 1'b1;
        wr_addr = w_q;
        for (int s = 0; s < 3; s++) begin
          wr_data[s*NW +: NW] = (row_w_q[s*NW +: NW] == v_q) ? b : row_w_q[s*NW +: NW];
        end
      end
      A_WR_V: begin
        wr_en   = 1'b1;
        wr_addr = v_q;
        for (int s = 0; s < 3; s++) begin
          if (row_v_q[s*NW +: NW] == u_n) begin
            wr_data[s*NW +: NW] = a_q;
          end else if (row_v_q[s*NW +: NW] == w_q) begin
            wr_data[s*NW +: NW] = b;
          end else begin
            wr_data[s*NW +: NW] = row_v_q[s*NW +: NW];
          end
        end
      end
      A_WR_A: begin
        wr_en   = 1'b1;
        wr_addr = a_q;
        wr_data = {v_q, b, u_n};
      end
      A_WR_B: begin
        wr_en   = 1'b1;
        wr_addr = b;
        wr_data = {w_q, a_q, v_q};
      end
      A_K4: begin
        wr_en   = 1'b1;
        wr_addr = NW'(ctl_i.k_row);
        wr_data = {NW'(k4_node(ctl_i.k_row, 2'd2)), NW'(k4_node(ctl_i.k_row, 2'd1)),
                   NW'(k4_node(ctl_i.k_row, 2'd0))};
      end
      default: begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.act)
      A_LATCH: begin
        u_q     <= req_i.edge_node;
        slot_q  <= req_i.edge_slot;
        rnode_q <= req_i.read_node;
      end
      A_GET_V: begin
        row_u_q <= rdata_q;
        a_q     <= NW'(cnt_q);
        unique case (slot_q)
          2'd1:    v_q <= rdata_q[NW +: NW];
          2'd2:    v_q <= rdata_q[2*NW +: NW];
          default: v_q <= rdata_q[0 +: NW];
        endcase
      end
      A_GET_W: begin
        row_v_q <= rdata_q;
        // successor of u in v's cyclic list; slot 1 when u is missing
        if (rdata_q[0 +: NW] == u_n) begin
          w_q <= rdata_q[NW +: NW];
        end else if (rdata_q[NW +: NW] == u_n) begin
          w_q <= rdata_q[2*NW +: NW];
        end else if (rdata_q[2*NW +: NW] == u_n) begin
          w_q <= rdata_q[0 +: NW];
        end else begin
          w_q <= rdata_q[NW +: NW];
        end
      end
      A_WR_U: begin
        row_w_q <= rdata_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= cnt_t'(4);
    end else if (ctl_i.act == A_K4) begin
      cnt_q <= cnt_t'(4);
    end else if (ctl_i.act == A_WR_B) begin
      cnt_q <= cnt_q + cnt_t'(2);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_count_q <= CountFieldW'(cnt_q);
      out_first_q <= '0;
      out_nb0_q   <= '0;
      out_nb1_q   <= '0;
      out_nb2_q   <= '0;
      unique case (ctl_i.act)
        A_EMIT_GROW: begin
          out_status_q <= STAT_OK;
          out_first_q  <= NodeFieldW'(a_q);
        end
        A_EMIT_READ: begin
          out_status_q <= STAT_OK;
          out_nb0_q    <= NodeFieldW'(rdata_q[0 +: NW]);
          out_nb1_q    <= NodeFieldW'(rdata_q[NW +: NW]);
          out_nb2_q    <= NodeFieldW'(rdata_q[2*NW +: NW]);
        end
        A_EMIT_RANGE: out_status_q <= STAT_RANGE;
        A_EMIT_FULL:  out_status_q <= STAT_FULL;
        default:      out_status_q <= STAT_OK;
      endcase
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = out_status_q;
  assign rsp_o.node_count       = out_count_q;
  assign rsp_o.first_new_node   = out_first_q;
  assign rsp_o.neighbour_first  = out_nb0_q;
  assign rsp_o.neighbour_second = out_nb1_q;
  assign rsp_o.neighbour_third  = out_nb2_q;

`ifndef ASSERT_OFF
  a_count_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] == 1'b0) else $error("node count became odd");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q >= cnt_t'(4)) && (cnt_q <= cnt_t'(TABLE_DEPTH)))
    else $error("node count out of bounds");
`endif

endmodule

/* rtl/core/cubic_planar_graph_grower_unit.sv */
// Cubic planar graph grower, top level. One request is handled at a time: a new
// request is taken only after the previous one has placed its response in the
// result register. Reset clears control state; the K4 rows are then loaded by the
// microprogram, and requests are taken once that load has finished.
// Depends on cpgg_pkg, cpgg_if, cpgg_sequencer and cpgg_datapath.
module cubic_planar_graph_grower_unit #(
  parameter int unsigned TABLE_DEPTH = cpgg_pkg::MaxNodes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpgg_req_if.sink   req_i,
  cpgg_rsp_if.source rsp_o
);
  import cpgg_pkg::*;

  uword_t ctl;
  flags_t flags;

  cpgg_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  cpgg_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .flags_o (flags),
    .req_i   (req_i),
    .rsp_o   (rsp_o)
  );

endmodule
